/* rtl/nrbw_pkg.sv */
// Shared types and constants for the per-block row bandwidth tracker.
// No dependencies; every other file of the block imports it.
package nrbw_pkg;

  localparam int IDX_W  = 20;
  localparam int NP_W   = 21;
  localparam int NB_W   = 7;
  localparam int SEL_W  = 6;
  localparam int DIV_W  = 21;
  localparam int CNT_W  = 5;
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  localparam logic REG_POINT_COUNT = 1'b0;
  localparam logic REG_NUM_BLOCKS  = 1'b1;

  typedef enum logic {
    OP_NEIGHBOR = 1'b0,
    OP_READ     = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CFG_DIV,
    ST_ROW_DIV,
    ST_ROW_RD,
    ST_ROW_WR,
    ST_RD_WAIT
  } state_e;

  typedef struct packed {
    logic            wr;
    logic [NP_W-1:0] point_count;
    logic [NB_W-1:0] num_blocks;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

/* rtl/nrbw_in_if.sv */
// Input channel: neighbor items and read items, valid/ready handshake.
// Depends on nrbw_pkg.
interface nrbw_in_if import nrbw_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             op;
  logic [IDX_W-1:0] row_index;
  logic [IDX_W-1:0] neighbor_index;
  logic             last_of_row;
  logic [SEL_W-1:0] block_select;

  modport source (
    output valid, op, row_index, neighbor_index, last_of_row, block_select,
    input  ready
  );
  modport sink (
    input  valid, op, row_index, neighbor_index, last_of_row, block_select,
    output ready
  );
endinterface

/* rtl/nrbw_out_if.sv */
// Result channel: one block's bandwidth pair, valid/ready handshake.
// Depends on nrbw_pkg.
interface nrbw_out_if import nrbw_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SEL_W-1:0] block;
  logic [IDX_W-1:0] left_bandwidth;
  logic [IDX_W-1:0] right_bandwidth;

  modport source (
    output valid, block, left_bandwidth, right_bandwidth,
    input  ready
  );
  modport sink (
    input  valid, block, left_bandwidth, right_bandwidth,
    output ready
  );
endinterface

/* rtl/nrbw_div.sv */
// Iterative restoring divider, one quotient bit per cycle.
// Depends on nrbw_pkg (div_req_t, div_rsp_t, DIV_W).
module nrbw_div import nrbw_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_W:0]   rem_q, rem_d;
  logic [DIV_W-1:0] quo_q, quo_d;
  logic [DIV_W-1:0] dsr_q, dsr_d;
  logic [DIV_W:0]   shifted;

  always_comb begin
    shifted = {rem_q[DIV_W-1:0], quo_q[DIV_W-1]};
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    dsr_d   = dsr_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dsr_d  = req_i.divisor;
    end else if (busy_q) begin
      if (shifted >= {1'b0, dsr_q}) begin
        rem_d = shifted - {1'b0, dsr_q};
        quo_d = {quo_q[DIV_W-2:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[DIV_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(DIV_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

/* rtl/nrbw_regs.sv */
// APB register file: point_count and num_blocks, with write strobe.
// Depends on nrbw_pkg (cfg_t, register indexes).
module nrbw_regs import nrbw_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  logic            wr;
  logic [NP_W-1:0] np_q, np_d;
  logic [NB_W-1:0] nb_q, nb_d;

  always_comb begin
    wr   = psel && penable && pwrite;
    np_d = np_q;
    nb_d = nb_q;
    if (wr) begin
      case (paddr[2])
        REG_POINT_COUNT: np_d = pwdata[NP_W-1:0];
        REG_NUM_BLOCKS:  nb_d = pwdata[NB_W-1:0];
        default: ;
      endcase
    end
    case (paddr[2])
      REG_POINT_COUNT: prdata = APB_DW'(np_q);
      REG_NUM_BLOCKS:  prdata = APB_DW'(nb_q);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      np_q <= '0;
      nb_q <= NB_W'(1);
    end else begin
      np_q <= np_d;
      nb_q <= nb_d;
    end
  end

  assign pready            = 1'b1;
  assign cfg_o.wr          = wr;
  assign cfg_o.point_count = np_q;
  assign cfg_o.num_blocks  = nb_q;

endmodule

/* rtl/nrbw_core.sv */
// Sequencer, running min/max and the bandwidth table memory.
// Depends on nrbw_pkg, nrbw_in_if, nrbw_out_if; drives the shared divider.
module nrbw_core import nrbw_pkg::*; #(
  parameter int MAX_BLOCKS = 64
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  nrbw_in_if.sink  in_i,
  nrbw_out_if.source res_o,
  input  cfg_t     cfg_i,
  output div_req_t div_req_o,
  input  div_rsp_t div_rsp_i
);

  localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int MW = 2 * IDX_W;

  state_e           state_q, state_d;
  logic [AW-1:0]    clr_addr_q, clr_addr_d;
  logic             in_row_q, in_row_d;
  logic             cfg_dirty_q, cfg_dirty_d;
  logic [NP_W-1:0]  rpb_q, rpb_d;
  logic [IDX_W-1:0] row_q, row_d, min_q, min_d, max_q, max_d;
  logic [IDX_W-1:0] lbw_q, lbw_d, rbw_q, rbw_d;
  logic [AW-1:0]    blk_q, blk_d;
  logic [SEL_W-1:0] sel_q, sel_d;
  logic             rd_zero_q, rd_zero_d;

  logic [MW-1:0]    mem_q [MAX_BLOCKS];
  logic [MW-1:0]    mem_rdata_q;
  logic             mem_we, mem_re;
  logic [AW-1:0]    mem_waddr, mem_raddr;
  logic [MW-1:0]    mem_wdata;

  logic             out_valid_q, out_valid_d, out_load;
  logic [SEL_W-1:0] out_block_q;
  logic [IDX_W-1:0] out_left_q, out_right_q;

  logic [NB_W-1:0]  nb_eff;
  logic [NP_W-1:0]  nb_ext, blk_full;
  logic             np_zero, accept;
  logic [IDX_W-1:0] base, cur_min, cur_max, min_new, max_new;
  logic [IDX_W-1:0] old_l, old_r;

  always_comb begin
    if (cfg_i.num_blocks == '0) begin
      nb_eff = NB_W'(1);
    end else if (32'(cfg_i.num_blocks) > 32'(MAX_BLOCKS)) begin
      nb_eff = NB_W'(MAX_BLOCKS);
    end else begin
      nb_eff = cfg_i.num_blocks;
    end
    nb_ext   = NP_W'(nb_eff);
    np_zero  = (cfg_i.point_count == '0);
    blk_full = (div_rsp_i.quotient >= nb_ext) ? nb_ext - NP_W'(1) : div_rsp_i.quotient;

    accept  = in_i.valid && in_i.ready;
    base    = in_row_q ? row_q : in_i.row_index;
    cur_min = in_row_q ? min_q : in_i.row_index;
    cur_max = in_row_q ? max_q : in_i.row_index;
    min_new = (in_i.neighbor_index < cur_min) ? in_i.neighbor_index : cur_min;
    max_new = (in_i.neighbor_index > cur_max) ? in_i.neighbor_index : cur_max;
    old_l   = mem_rdata_q[MW-1:IDX_W];
    old_r   = mem_rdata_q[IDX_W-1:0];
  end

  always_comb begin
    state_d     = state_q;
    clr_addr_d  = clr_addr_q;
    in_row_d    = in_row_q;
    cfg_dirty_d = cfg_dirty_q || cfg_i.wr;
    rpb_d       = rpb_q;
    row_d       = row_q;
    min_d       = min_q;
    max_d       = max_q;
    lbw_d       = lbw_q;
    rbw_d       = rbw_q;
    blk_d       = blk_q;
    sel_d       = sel_q;
    rd_zero_d   = rd_zero_q;
    mem_we      = 1'b0;
    mem_waddr   = blk_q;
    mem_wdata   = '0;
    mem_re      = 1'b0;
    mem_raddr   = blk_q;
    out_load    = 1'b0;
    in_i.ready  = 1'b0;
    div_req_o.start    = 1'b0;
    div_req_o.dividend = DIV_W'(base);
    div_req_o.divisor  = rpb_q;

    case (state_q)
      ST_CLEAR: begin
        mem_we     = 1'b1;
        mem_waddr  = clr_addr_q;
        clr_addr_d = clr_addr_q + AW'(1);
        if (clr_addr_q == AW'(MAX_BLOCKS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_i.ready = !cfg_dirty_q;
        if (cfg_dirty_q) begin
          cfg_dirty_d = cfg_i.wr;
          if (np_zero) begin
            rpb_d = NP_W'(1);
          end else begin
            div_req_o.start    = 1'b1;
            div_req_o.dividend = cfg_i.point_count - NP_W'(1);
            div_req_o.divisor  = nb_ext;
            state_d            = ST_CFG_DIV;
          end
        end else if (accept) begin
          if (in_i.op == OP_READ) begin
            mem_re    = 1'b1;
            mem_raddr = AW'(in_i.block_select);
            sel_d     = in_i.block_select;
            rd_zero_d = 32'(in_i.block_select) >= 32'(MAX_BLOCKS);
            state_d   = ST_RD_WAIT;
          end else begin
            row_d = base;
            min_d = min_new;
            max_d = max_new;
            if (in_i.last_of_row) begin
              in_row_d = 1'b0;
              lbw_d    = base - min_new;
              rbw_d    = max_new - base;
              if (np_zero) begin
                blk_d   = '0;
                state_d = ST_ROW_RD;
              end else begin
                div_req_o.start = 1'b1;
                state_d         = ST_ROW_DIV;
              end
            end else begin
              in_row_d = 1'b1;
            end
          end
        end
      end
      ST_CFG_DIV: begin
        if (div_rsp_i.done) begin
          rpb_d   = div_rsp_i.quotient + DIV_W'(1);
          state_d = ST_IDLE;
        end
      end
      ST_ROW_DIV: begin
        if (div_rsp_i.done) begin
          blk_d   = AW'(blk_full);
          state_d = ST_ROW_RD;
        end
      end
      ST_ROW_RD: begin
        mem_re  = 1'b1;
        state_d = ST_ROW_WR;
      end
      ST_ROW_WR: begin
        mem_we    = 1'b1;
        mem_wdata = {(lbw_q > old_l) ? lbw_q : old_l, (rbw_q > old_r) ? rbw_q : old_r};
        state_d   = ST_IDLE;
      end
      ST_RD_WAIT: begin
        if (!out_valid_q || res_o.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_addr_q  <= '0;
      in_row_q    <= 1'b0;
      cfg_dirty_q <= 1'b0;
      rpb_q       <= NP_W'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_addr_q  <= clr_addr_d;
      in_row_q    <= in_row_d;
      cfg_dirty_q <= cfg_dirty_d;
      rpb_q       <= rpb_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q     <= row_d;
    min_q     <= min_d;
    max_q     <= max_d;
    lbw_q     <= lbw_d;
    rbw_q     <= rbw_d;
    blk_q     <= blk_d;
    sel_q     <= sel_d;
    rd_zero_q <= rd_zero_d;
    if (out_load) begin
      out_block_q <= sel_q;
      out_left_q  <= rd_zero_q ? '0 : old_l;
      out_right_q <= rd_zero_q ? '0 : old_r;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= mem_q[mem_raddr];
    end
  end

  assign res_o.valid           = out_valid_q;
  assign res_o.block           = out_block_q;
  assign res_o.left_bandwidth  = out_left_q;
  assign res_o.right_bandwidth = out_right_q;

  a_div_done_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp_i.done |-> (state_q == ST_CFG_DIV || state_q == ST_ROW_DIV))
    else $error("divider finished with no request outstanding");

  a_result_from_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_o.valid) |-> $past(state_q) == ST_RD_WAIT)
    else $error("result raised without a read item");

  a_row_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_row_q |-> (min_q <= row_q && max_q >= row_q))
    else $error("running min/max do not bracket the row index");

  a_no_item_stale_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_dirty_q |-> !(in_i.valid && in_i.ready))
    else $error("item accepted before block size was recomputed");

endmodule

/* rtl/neighbor_row_bandwidth_per_block.sv */
// Per-block row bandwidth tracker, top level.
// Depends on nrbw_pkg, nrbw_in_if, nrbw_out_if, nrbw_div, nrbw_regs, nrbw_core.
//
// in_i carries items: a neighbor item (op 0) gives one column index of a row,
// tagged with its row index and a last-of-row mark; a read item (op 1) asks
// for the largest left/right bandwidth recorded for one block. res_o returns
// one result per read item. point_count and num_blocks are written over APB.
// A neighbor item that does not end a row leaves the core ready for the next
// item. A row's last item stalls the input while the shared 21-bit divider
// finds the row's block, then a read and a write-back of the table memory.
// A read item stalls the input while its table entry is read into a register
// and then loaded into the output register once that is free. A register
// write stalls the input while the divider derives the block size.
// Reset clears the table memory one entry per cycle: no item is accepted until
// every entry is cleared. If res_o stalls, one result waits in the output
// register and neighbor items keep flowing; a second read item waits inside
// until the output register frees up.
module neighbor_row_bandwidth_per_block import nrbw_pkg::*; #(
  parameter int MAX_BLOCKS = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  nrbw_in_if.sink           in_i,
  nrbw_out_if.source        res_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  cfg_t     cfg;
  div_req_t div_req;
  div_rsp_t div_rsp;

  nrbw_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  nrbw_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  nrbw_core #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .res_o     (res_o),
    .cfg_i     (cfg),
    .div_req_o (div_req),
    .div_rsp_i (div_rsp)
  );

endmodule
